/* rtl/lcg_rng_pkg.sv */
// ----------------------------------------------------------------------------
// lcg_rng_pkg
// Shared types and constants for the linear congruential random source.
// ----------------------------------------------------------------------------
package lcg_rng_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd12345;

    localparam logic [FUNC_W-1:0] FUNC_SEED  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAW   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BELOW = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADV,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } div_rsp_t;

endpackage

/* rtl/lcg_rng_if.sv */
// ----------------------------------------------------------------------------
// lcg_rng_if
// Valid/ready channels for the request and result items.
// ----------------------------------------------------------------------------
interface lcg_rng_req_if;
    import lcg_rng_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

interface lcg_rng_rsp_if;
    import lcg_rng_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;
    logic              bad_bound;

    modport source (output valid, output value, output bad_bound, input ready);
    modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

/* rtl/lcg_rng_div.sv */
// ----------------------------------------------------------------------------
// lcg_rng_div
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcg_rng_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcg_rng_pkg::div_req_t req,
    output lcg_rng_pkg::div_rsp_t rsp
);
    import lcg_rng_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [WORD_W-1:0]    rem_reg,   rem_next;
    logic [WORD_W-1:0]    dvd_reg,   dvd_next;
    logic [WORD_W-1:0]    dvs_reg,   dvs_next;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      trial;

    assign shifted = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(WORD_W - 1);
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The remainder always stays below the divisor, so it fits one word.
            if (!trial[WORD_W])
                rem_next = trial[WORD_W-1:0];
            else
                rem_next = shifted[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/lcg_random_with_range.sv */
// ----------------------------------------------------------------------------
// lcg_random_with_range
// 32-bit linear congruential random source with bounded and ranged draws.
// ----------------------------------------------------------------------------
// Usage: request items arrive on req (func, operand_a, operand_b) and result
// items leave on rsp (value, bad_bound), both valid/ready channels.
// A seed item loads the state word and gives no result. A raw draw, a draw
// below a bound and a draw in a range each give exactly one result item.
// Timing: req.ready is high only while the sequencer is idle. A seed is
// taken while idle and leaves the sequencer idle. An empty range goes
// straight to the finish step, a raw draw or a zero bound through the
// advance step first. A reduced draw runs the shared restoring remainder
// unit, one bit per cycle, and then reaches the output register through the
// finish step; the next item is accepted once the sequencer is idle again.
// The output register holds one result; a new item is accepted while it
// waits, and the sequencer holds its finished result until rsp.ready frees
// the register, so a stalled receiver loses nothing.
// Reset clears the state word to zero and empties the output register.
// ----------------------------------------------------------------------------
module lcg_random_with_range (
    input  logic        clk,
    input  logic        rst_n,
    lcg_rng_req_if.sink   req,
    lcg_rng_rsp_if.source rsp
);
    import lcg_rng_pkg::*;

    state_t            state_reg, state_next;
    logic [FUNC_W-1:0] func_reg,  func_next;
    logic [WORD_W-1:0] opa_reg,   opa_next;
    logic [WORD_W-1:0] opb_reg,   opb_next;
    logic [WORD_W-1:0] lcg_reg,   lcg_next;
    logic [WORD_W-1:0] res_reg,   res_next;
    logic              bad_reg,   bad_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              badout_reg, badout_next;
    logic              ovalid_reg, ovalid_next;

    logic [WORD_W-1:0] adv_word;
    logic              range_empty;
    logic              no_div;
    logic              out_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign adv_word    = lcg_reg * LCG_MUL + LCG_ADD;
    assign range_empty = !(req.operand_b > req.operand_a);
    assign no_div      = (func_reg == FUNC_RAW) ||
                         ((func_reg == FUNC_BELOW) && (opa_reg == '0));
    assign out_free    = !ovalid_reg || rsp.ready;

    lcg_rng_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_SEED)
                        state_next = S_IDLE;
                    else if ((req.func == FUNC_RANGE) && range_empty)
                        state_next = S_FIN;
                    else
                        state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (no_div)
                    state_next = S_FIN;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        req.ready        = (state_reg == S_IDLE);
        func_next        = func_reg;
        opa_next         = opa_reg;
        opb_next         = opb_reg;
        lcg_next         = lcg_reg;
        res_next         = res_reg;
        bad_next         = bad_reg;
        value_next       = value_reg;
        badout_next      = badout_reg;
        ovalid_next      = ovalid_reg && !rsp.ready;
        div_req.start    = 1'b0;
        div_req.dividend = adv_word;
        div_req.divisor  = (func_reg == FUNC_BELOW) ? opa_reg : (opb_reg - opa_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                func_next = req.func;
                opa_next  = req.operand_a;
                opb_next  = req.operand_b;
                if (req.valid && (req.func == FUNC_SEED))
                    lcg_next = req.operand_a;
                // An empty or inverted range leaves the state word alone.
                res_next = req.operand_a;
                bad_next = 1'b0;
            end
            S_ADV:
            begin
                lcg_next      = adv_word;
                div_req.start = !no_div;
                if (func_reg == FUNC_RAW)
                begin
                    res_next = adv_word;
                    bad_next = 1'b0;
                end
                else
                begin
                    res_next = '0;
                    bad_next = 1'b1;
                end
            end
            S_DIV:
            begin
                res_next = div_rsp.rem + ((func_reg == FUNC_RANGE) ? opa_reg : '0);
                bad_next = 1'b0;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    value_next  = res_reg;
                    badout_next = bad_reg;
                    ovalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lcg_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lcg_reg    <= lcg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        res_reg    <= res_next;
        bad_reg    <= bad_next;
        value_reg  <= value_next;
        badout_reg <= badout_next;
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.value     = value_reg;
    assign rsp.bad_bound = badout_reg;

`ifndef SYNTHESIS
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(ovalid_reg) |-> $past(state_reg == S_FIN)))
        else $error("result register loaded outside the finish step");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.done |-> (state_reg == S_DIV)))
        else $error("remainder finished while the sequencer was not waiting");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((ovalid_reg && badout_reg) |-> (value_reg == '0)))
        else $error("bad bound result carries a non-zero value");

    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((req.valid && req.ready && (req.func == FUNC_SEED)) |=> (state_reg == S_IDLE)))
        else $error("seed item started a draw");
`endif

endmodule

/* sim/lcg_random_with_range_test.sv */
// ----------------------------------------------------------------------------
// lcg_random_with_range_test
// Self-checking bench for the linear congruential random source: drives
// seed, raw, bounded and ranged draw items with bursty traffic, stalls the
// result side, and compares every result item against a local LCG predictor.
// ----------------------------------------------------------------------------
module lcg_random_with_range_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcg_rng_pkg::*;

    localparam logic [WORD_W-1:0] MULTIPLIER = 32'd1103515245;
    localparam logic [WORD_W-1:0] INCREMENT  = 32'd12345;

    localparam int unsigned RANDOM_ITEMS     = 1250;
    localparam int unsigned LONG_HOLD_AT     = 400;
    localparam int unsigned DRAIN_AT         = 800;
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    localparam int unsigned SETTLE_CYCLES    = 80;
    localparam int unsigned TIMEOUT_CYCLES   = 600000;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              bad_bound;
    } draw_t;

    // Tracks the generator word and the draws still owed by the block.
    class draw_ledger;
        logic [WORD_W-1:0] lcg_word;
        draw_t             owed[$];
        int unsigned       mismatches;

        function new();
            lcg_word   = '0;
            mismatches = 0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] op, logic [WORD_W-1:0] a,
                                   logic [WORD_W-1:0] b);
            draw_t due;
            due.value     = '0;
            due.bad_bound = 1'b0;
            if (op == FUNC_SEED) begin
                lcg_word = a;
            end
            else begin
                if (op == FUNC_RAW) begin
                    lcg_word  = lcg_word * MULTIPLIER + INCREMENT;
                    due.value = lcg_word;
                end
                else if (op == FUNC_BELOW) begin
                    lcg_word = lcg_word * MULTIPLIER + INCREMENT;
                    if (a == '0)
                        due.bad_bound = 1'b1;
                    else
                        due.value = lcg_word % a;
                end
                else if (b > a) begin
                    lcg_word  = lcg_word * MULTIPLIER + INCREMENT;
                    due.value = a + (lcg_word % (b - a));
                end
                else begin
                    // An empty or inverted range leaves the word untouched.
                    due.value = a;
                end
                owed.push_back(due);
            end
        endfunction

        function void check_draw(logic [WORD_W-1:0] value, logic bad_bound);
            draw_t due;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: value %h bad_bound %b",
                             value, bad_bound);
            end
            else begin
                due = owed.pop_front();
                if (value !== due.value || bad_bound !== due.bad_bound) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("draw mismatch: expected value %h bad_bound %b, got %h %b",
                                 due.value, due.bad_bound, value, bad_bound);
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic long_hold_req;
    int unsigned cycle_count;
    draw_ledger ledger;

    lcg_rng_req_if req_if ();
    lcg_rng_rsp_if rsp_if ();

    lcg_random_with_range dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    // Both channels are sampled at the edge, before the registered outputs move.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                ledger.check_draw(rsp_if.value, rsp_if.bad_bound);
            if (req_if.valid && req_if.ready)
                ledger.note_request(req_if.func, req_if.operand_a, req_if.operand_b);
        end
    end

    // Result side: changing stall patterns, plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned segment;
        int unsigned mode;
        int unsigned period;
        segment = 0;
        mode    = 0;
        period  = 2;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (segment == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    segment = $urandom_range(16, 160);
                    period  = $urandom_range(2, 7);
                end
                segment--;
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ((segment % period) != 0);
                endcase
            end
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'd1 << $urandom_range(0, 31);
            4: return 32'($urandom_range(0, 255));
            default: return 32'($urandom());
        endcase
    endfunction

    // Holds valid high and returns at the edge where the item is taken.
    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b);
        req_if.valid     <= 1'b1;
        req_if.func      <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [FUNC_W-1:0] op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        pick = $urandom_range(0, 99);
        a    = pick_word();
        b    = 32'($urandom());
        if (pick < 10)
            op = FUNC_SEED;
        else if (pick < 35)
        begin
            op = FUNC_RAW;
            a  = 32'($urandom());
        end
        else if (pick < 67)
        begin
            op = FUNC_BELOW;
            if ($urandom_range(0, 19) == 0)
                a = '0;
        end
        else
        begin
            op = FUNC_RANGE;
            // Mostly a well-formed range; the rest may be empty or inverted.
            if ($urandom_range(0, 9) < 8 && a != '1)
                b = a + 32'd1 + (32'($urandom()) % ('1 - a));
            else
                b = pick_word();
        end
        send_item(op, a, b);
    endtask

    initial
    begin : stimulus
        int unsigned burst_left;
        int unsigned gap;
        bit pause;
        ledger        = new();
        long_hold_req = 1'b0;
        burst_left    = 0;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_SEED;
        req_if.operand_a <= '0;
        req_if.operand_b <= '0;
        rst_n            <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: draw straight from reset, extremes and the edge cases.
        send_item(FUNC_RAW,   32'h0,        32'h0);
        send_item(FUNC_RAW,   '1,           '1);
        send_item(FUNC_SEED,  '1,           '1);
        send_item(FUNC_RAW,   32'h0,        32'h0);
        send_item(FUNC_SEED,  32'h0,        32'h0);
        send_item(FUNC_BELOW, 32'h0,        '1);
        send_item(FUNC_BELOW, 32'h1,        32'h0);
        send_item(FUNC_BELOW, '1,           32'h0);
        send_item(FUNC_BELOW, 32'h8000_0000, '1);
        send_item(FUNC_BELOW, 32'h7,        32'h0);
        send_item(FUNC_RANGE, 32'h0,        '1);
        send_item(FUNC_RANGE, 32'hFFFF_FFFE, '1);
        send_item(FUNC_RANGE, 32'h5,        32'h5);
        send_item(FUNC_RANGE, '1,           32'h0);
        send_item(FUNC_RANGE, 32'h0,        32'h0);
        send_item(FUNC_RANGE, 32'd10,       32'd11);
        send_item(FUNC_RANGE, 32'h0,        32'h1);
        send_item(FUNC_RANGE, 32'h8000_0000, 32'h8000_1000);
        send_item(FUNC_SEED,  32'h1234_5678, 32'hDEAD_BEEF);
        send_item(FUNC_RAW,   32'hA5A5_A5A5, 32'h5A5A_5A5A);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == LONG_HOLD_AT)
                long_hold_req = 1'b1;
            pause = (n == DRAIN_AT);
            gap   = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 12);
            end
            burst_left--;
            if (pause || gap != 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if (pause)
                    do @(posedge clk); while (ledger.outstanding() != 0);
            end
            send_random_item();
        end

        req_if.valid <= 1'b0;
        do @(posedge clk); while (ledger.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", ledger.mismatches,
                     ledger.outstanding());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lcg_rng_pkg.sv
rtl/lcg_rng_if.sv
rtl/lcg_rng_div.sv
rtl/lcg_random_with_range.sv
sim/lcg_random_with_range_test.sv
